>>> design/ttc_pkg.sv
// Shared types, codes and the mate score correction for the transposition table cache.
`default_nettype none

package ttc_pkg;

	localparam int TABLE_ENTRIES_DEF = 4096;
	localparam int SCORE_W           = 24;
	localparam int THR_W             = 23;
	localparam int CFG_W             = 23;
	localparam int CFG_IDX_W         = 1;

	localparam logic [THR_W-1:0] MATE_THRESHOLD_RST = 23'd99000;
	localparam logic             TABLE_ENABLED_RST  = 1'b1;

	// operation codes
	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_STORE  = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// bound codes
	localparam logic [1:0] BOUND_EXACT = 2'd0;
	localparam logic [1:0] BOUND_LOWER = 2'd1;
	localparam logic [1:0] BOUND_UPPER = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_ENABLED  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MATE_THRESHOLD = 1'b1;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7FFFFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;

	typedef struct packed {
		logic [1:0]                kind;
		logic [63:0]               position_key;
		logic [7:0]                search_depth;
		logic [7:0]                ply;
		logic signed [SCORE_W-1:0] alpha;
		logic signed [SCORE_W-1:0] beta;
		logic signed [SCORE_W-1:0] eval_score;
		logic [1:0]                bound_type;
		logic [15:0]               best_move;
	} ttc_in_t;

	typedef struct packed {
		logic                      hit;
		logic signed [SCORE_W-1:0] score;
		logic [15:0]               slot_move;
	} ttc_out_t;

	typedef struct packed {
		logic [63:0]               key;
		logic signed [SCORE_W-1:0] score;
		logic [7:0]                depth;
		logic [1:0]                bound;
		logic [15:0]               move;
	} ttc_entry_t;

	// Shift a mate score by ply: away from zero when away is set, else toward zero.
	// Saturate to the score range.
	function automatic logic signed [SCORE_W-1:0] mate_adjust(
		input logic signed [SCORE_W-1:0] s,
		input logic [7:0]                ply,
		input logic                      away,
		input logic [THR_W-1:0]          thr
	);
		logic [SCORE_W-1:0]          mag;
		logic signed [SCORE_W+1:0]   m;
		logic signed [SCORE_W+1:0]   v;
		logic signed [SCORE_W-1:0]   r;
		mag = s[SCORE_W-1] ? (~s + 24'd1) : s;
		if (mag <= {1'b0, thr}) begin
			r = s;
		end else begin
			if (away) begin
				m = $signed({2'b00, mag}) + $signed({18'd0, ply});
			end else begin
				m = $signed({2'b00, mag}) - $signed({18'd0, ply});
			end
			v = s[SCORE_W-1] ? -m : m;
			if (v > 26'sd8388607) begin
				r = SCORE_MAX;
			end else if (v < -26'sd8388608) begin
				r = SCORE_MIN;
			end else begin
				r = v[SCORE_W-1:0];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> design/ttc_in_if.sv
// Request channel: valid, ready and one operation beat.
`default_nettype none

interface ttc_in_if;
	logic              valid;
	logic              ready;
	ttc_pkg::ttc_in_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/ttc_out_if.sv
// Response channel: valid, ready and one result beat.
`default_nettype none

interface ttc_out_if;
	logic              valid;
	logic              ready;
	ttc_pkg::ttc_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/ttc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module ttc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

>>> design/ttc_probe.sv
// Lookup evaluation: key and depth match, mate correction, then the bound check.
`default_nettype none

module ttc_probe (
	input  wire logic                         clk,
	input  wire logic                         capture,
	input  wire logic                         enabled,
	input  wire logic [ttc_pkg::THR_W-1:0]    thr,
	input  wire ttc_pkg::ttc_entry_t          entry,
	input  wire ttc_pkg::ttc_in_t             req,
	output ttc_pkg::ttc_out_t                 res
);

	logic                                 match_s2;
	logic signed [ttc_pkg::SCORE_W-1:0]   score_s2;
	logic [1:0]                           bound_s2;
	logic [15:0]                          move_s2;
	logic signed [ttc_pkg::SCORE_W-1:0]   alpha_s2;
	logic signed [ttc_pkg::SCORE_W-1:0]   beta_s2;
	logic                                 hit;

	// hold the stage until the next read comes back
	always_ff @(posedge clk) begin
		if (capture) begin
			match_s2 <= enabled && (entry.key == req.position_key)
				&& (entry.depth >= req.search_depth);
			score_s2 <= ttc_pkg::mate_adjust(entry.score, req.ply, 1'b0, thr);
			bound_s2 <= entry.bound;
			move_s2  <= entry.move;
			alpha_s2 <= req.alpha;
			beta_s2  <= req.beta;
		end
	end

	always_comb begin
		hit = match_s2 && ((bound_s2 == ttc_pkg::BOUND_EXACT)
			|| ((bound_s2 == ttc_pkg::BOUND_UPPER) && (score_s2 <= alpha_s2))
			|| ((bound_s2 == ttc_pkg::BOUND_LOWER) && (score_s2 >= beta_s2)));
		res.hit       = hit;
		res.score     = hit ? score_s2 : '0;
		res.slot_move = move_s2;
	end

endmodule

`default_nettype wire

>>> design/transposition_table_cache.sv
// Top level of the direct-mapped transposition table cache.
//
// Usage
//   req carries one operation a beat: lookup, store or clear of the whole table.
//   rsp returns exactly one result beat for every request beat, in order:
//   hit, corrected score and the move held in the indexed slot (lookups only;
//   stores, clears and the unused kind return all zeros).
//   cfg_we / cfg_index / cfg_wdata write table_enabled (index 0) and
//   mate_threshold (index 1); write them only while the block is idle.
// Timing
//   All entries live in one single-port RAM with a registered read.
//   A lookup passes address, read and evaluate before the next accept; a
//   store passes capture, write and reply. The unused kind is captured
//   and replied to. A clear sweeps the RAM one entry a cycle, then replies.
//   Evaluation ends by loading the result into the output register.
// Reset
//   After arst_n releases, a pass over all TABLE_ENTRIES entries zeroes the
//   RAM with req.ready low; configuration writes are taken throughout.
// Stalls
//   A finished result waits in the output register; one further request is
//   accepted and worked up to its reply, which then holds until rsp drains.
`default_nettype none

module transposition_table_cache #(
	parameter int TABLE_ENTRIES = ttc_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ttc_in_if.sink                             req,
	ttc_out_if.source                          rsp,
	input  wire logic                          cfg_we,
	input  wire logic [ttc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ttc_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int ENTRY_W = $bits(ttc_pkg::ttc_entry_t);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_EVAL  = 6'b001000,
		ST_STORE = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [IDX_W-1:0]                sweep_q;
	logic                            clear_reply_q;
	logic                            enabled_q;
	logic [ttc_pkg::THR_W-1:0]       thr_q;
	ttc_pkg::ttc_in_t                req_q;
	logic                            rsp_valid_q;
	ttc_pkg::ttc_out_t               rsp_data_q;

	logic                            req_acc;
	logic                            out_free;
	logic                            ram_we;
	logic [IDX_W-1:0]                ram_addr;
	ttc_pkg::ttc_entry_t             ram_wdata;
	ttc_pkg::ttc_entry_t             ram_rdata;
	logic [ENTRY_W-1:0]              ram_rdata_raw;
	ttc_pkg::ttc_out_t               probe_res;
	ttc_pkg::ttc_entry_t             store_entry;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= ttc_pkg::TABLE_ENABLED_RST;
			thr_q     <= ttc_pkg::MATE_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ttc_pkg::REG_TABLE_ENABLED:  enabled_q <= cfg_wdata[0];
				ttc_pkg::REG_MATE_THRESHOLD: thr_q     <= cfg_wdata[ttc_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// capture the request beat
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req.data;
		end
	end

	// entry written by a store: score moved away from zero when it is a mate score
	always_comb begin
		store_entry.key   = req_q.position_key;
		store_entry.score = ttc_pkg::mate_adjust(req_q.eval_score, req_q.ply, 1'b1, thr_q);
		store_entry.depth = req_q.search_depth;
		store_entry.bound = req_q.bound_type;
		store_entry.move  = req_q.best_move;
	end

	// RAM port: sweep address while clearing, the live beat's index on accept, else the captured beat's
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '0;
		ram_addr  = req_q.position_key[IDX_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = sweep_q;
			end
			ST_IDLE: begin
				ram_addr = req.data.position_key[IDX_W-1:0];
			end
			ST_STORE: begin
				ram_we    = enabled_q;
				ram_wdata = store_entry;
			end
			default: ;
		endcase
	end

	ttc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = ram_rdata_raw;

	ttc_probe u_probe (
		.clk     (clk),
		.capture (state_q == ST_READ),
		.enabled (enabled_q),
		.thr     (thr_q),
		.entry   (ram_rdata),
		.req     (req_q),
		.res     (probe_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			sweep_q       <= '0;
			clear_reply_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + IDX_W'(1);
					if (&sweep_q) begin
						state_q <= clear_reply_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						case (req.data.kind)
							ttc_pkg::KIND_LOOKUP: state_q <= ST_READ;
							ttc_pkg::KIND_STORE:  state_q <= ST_STORE;
							ttc_pkg::KIND_CLEAR: begin
								state_q       <= ST_CLEAR;
								sweep_q       <= '0;
								clear_reply_q <= 1'b1;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_READ:  state_q <= ST_EVAL;
				ST_STORE: state_q <= ST_DONE;
				ST_EVAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: load a lookup result or an all-zero reply, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (((state_q == ST_EVAL) || (state_q == ST_DONE)) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_EVAL) begin
				rsp_data_q <= probe_res;
			end else if (state_q == ST_DONE) begin
				rsp_data_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/ttc_checker.sv
// Port-level checks for the transposition table cache, bound to the top level.
`default_nettype none

module ttc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire ttc_pkg::ttc_out_t rsp_data
);

	logic       req_acc;
	logic       rsp_acc;
	logic [1:0] pend_q;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// count beats accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_acc) - 2'(rsp_acc);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken while previous beat still in work");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two beats outstanding");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an outstanding request");

endmodule

bind transposition_table_cache ttc_checker u_ttc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
